>>> design/cfd_pkg.sv
// Shared types, constants and helpers for the chunked FLV tag deframer.
`default_nettype none
package cfd_pkg;

  localparam logic [7:0] CHAR_CR = 8'h0d;
  localparam logic [7:0] CHAR_LF = 8'h0a;

  localparam int unsigned TAG_SIZE_BYTES = 3;
  localparam logic [24:0] TAG_TRAILER_BYTES = 25'd11;

  typedef enum logic [1:0] {
    PH_TYPE = 2'd0,
    PH_SIZE = 2'd1,
    PH_BODY = 2'd2
  } tag_phase_e;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } tag_res_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t r;
    r.valid = 1'b1;
    r.value = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r.value = c[3:0];
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      r.value = c[3:0] + 4'd9;
    end else begin
      r.valid = 1'b0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> design/cfd_chunk.sv
// Chunk-size line decoder: separates payload bytes from size-line bytes.
`default_nettype none
module cfd_chunk
  import cfd_pkg::*;
#(
  parameter int unsigned CHUNK_COUNT_BITS = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       en_i,
  input  wire logic       chunked_i,
  input  wire logic [7:0] byte_i,
  output logic            payload_o
);

  localparam int unsigned CW = CHUNK_COUNT_BITS;

  logic [CW-1:0] chunk_left_q, chunk_left_d;
  logic [CW-1:0] hex_accum_q, hex_accum_d;
  hex_digit_t    digit;

  assign digit = hex_decode(byte_i);

  always_comb begin
    chunk_left_d = chunk_left_q;
    hex_accum_d  = hex_accum_q;
    payload_o    = 1'b1;
    if (chunked_i) begin
      if (chunk_left_q == '0) begin
        payload_o = 1'b0;
        if (byte_i == CHAR_LF) begin
          chunk_left_d = hex_accum_q;
          hex_accum_d  = '0;
        end else if (byte_i != CHAR_CR && digit.valid) begin
          hex_accum_d = {hex_accum_q[CW-5:0], digit.value};
        end
      end else begin
        chunk_left_d = chunk_left_q - {{(CW-1){1'b0}}, 1'b1};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_left_q <= '0;
      hex_accum_q  <= '0;
    end else if (en_i) begin
      chunk_left_q <= chunk_left_d;
      hex_accum_q  <= hex_accum_d;
    end
  end

endmodule
`default_nettype wire

>>> design/cfd_framer.sv
// FLV file-header skip and tag framing with first/last marks.
`default_nettype none
module cfd_framer
  import cfd_pkg::*;
#(
  parameter int unsigned FILE_HEADER_BYTES = 13
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       en_i,
  input  wire logic       payload_i,
  input  wire logic [7:0] byte_i,
  output tag_res_t        res_o
);

  localparam logic [3:0] HDR_RESET = FILE_HEADER_BYTES[3:0];

  logic [3:0]  header_left_q, header_left_d;
  tag_phase_e  phase_q, phase_d;
  logic [1:0]  size_seen_q, size_seen_d;
  logic [23:0] data_size_q, data_size_d;
  logic [24:0] done_q, done_d;
  logic [24:0] done_inc;

  assign done_inc = done_q + 25'd1;

  always_comb begin
    header_left_d = header_left_q;
    phase_d       = phase_q;
    size_seen_d   = size_seen_q;
    data_size_d   = data_size_q;
    done_d        = done_q;
    res_o         = '0;
    if (payload_i) begin
      if (header_left_q != 4'd0) begin
        header_left_d = header_left_q - 4'd1;
      end else begin
        res_o.valid = 1'b1;
        case (phase_q)
          PH_SIZE: begin
            data_size_d = {data_size_q[15:0], byte_i};
            size_seen_d = size_seen_q + 2'd1;
            if (size_seen_q == 2'(TAG_SIZE_BYTES - 1)) begin
              size_seen_d = 2'd0;
              done_d      = '0;
              phase_d     = PH_BODY;
            end
          end
          PH_BODY: begin
            done_d = done_inc;
            if (done_inc >= {1'b0, data_size_q} + TAG_TRAILER_BYTES) begin
              res_o.last  = 1'b1;
              done_d      = '0;
              data_size_d = '0;
              phase_d     = PH_TYPE;
            end
          end
          default: begin
            res_o.first = 1'b1;
            phase_d     = PH_SIZE;
            size_seen_d = 2'd0;
            data_size_d = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_left_q <= HDR_RESET;
      phase_q       <= PH_TYPE;
      size_seen_q   <= 2'd0;
      data_size_q   <= '0;
      done_q        <= '0;
    end else if (en_i) begin
      header_left_q <= header_left_d;
      phase_q       <= phase_d;
      size_seen_q   <= size_seen_d;
      data_size_q   <= data_size_d;
      done_q        <= done_d;
    end
  end

endmodule
`default_nettype wire

>>> design/chunked_flv_tag_deframer.sv
// An accepted byte is held in the input register, then moves to the result register.
// Throughput: one byte per cycle while results are taken, through input and result registers.
// A result waiting to be taken stalls the input side once the input register holds a byte.
// Reset (rst_ni low, asynchronous): chunked mode off, header skip reloaded,
// chunk counters and tag framing cleared, both stages empty.
`default_nettype none
module chunked_flv_tag_deframer
  import cfd_pkg::*;
#(
  parameter int unsigned CHUNK_COUNT_BITS  = 32,
  parameter int unsigned FILE_HEADER_BYTES = 13
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic       cfg_data_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] data_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      tag_byte_o,
  output logic            tag_first_o,
  output logic            tag_last_o
);

  logic       chunked_q;
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_first_q, out_last_q;
  logic       advance;
  logic       payload;
  tag_res_t   res;

  assign cfg_ready_o = 1'b1;
  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;

  cfd_chunk #(
    .CHUNK_COUNT_BITS(CHUNK_COUNT_BITS)
  ) u_chunk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .chunked_i(chunked_q),
    .byte_i   (in_byte_q),
    .payload_o(payload)
  );

  cfd_framer #(
    .FILE_HEADER_BYTES(FILE_HEADER_BYTES)
  ) u_framer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .payload_i(payload),
    .byte_i   (in_byte_q),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunked_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      chunked_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= data_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res.valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.valid) begin
      out_byte_q  <= in_byte_q;
      out_first_q <= res.first;
      out_last_q  <= res.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign tag_byte_o  = out_byte_q;
  assign tag_first_o = out_first_q;
  assign tag_last_o  = out_last_q;

`ifndef SYNTHESIS
  a_first_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_first_q && out_last_q))
    else $error("tag byte marked both first and last");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without a blocked result");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res.valid) |=> out_valid_q)
    else $error("result transfer lost");
`endif

endmodule
`default_nettype wire
